>>> rtl/iir_direct_form_two_filter_macros.svh
// ----------------------------------------------------------------------------
// iir direct form two filter assertion macros
// concurrent assertion shorthands on clock with reset disable
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_TWO_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_MACROS_SVH

// same-cycle implication
`define IIRDF2_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IIRDF2_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/iirdf2_pkg.sv
// ----------------------------------------------------------------------------
// iirdf2_pkg
// shared widths, register indexes and controller command types
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf2_pkg;

   localparam int ORDER_DEF       = 3;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int COEF_BITS     = 24;
   localparam int COEF_FRAC     = 20;
   localparam int HIST_BITS     = 32;
   localparam int HIST_FRAC     = 8;
   localparam int PROD_BITS     = COEF_BITS + HIST_BITS;
   localparam int ACC_BITS      = PROD_BITS + 2;
   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_BITS  = 3;
   localparam int CSR_IDX_BITS  = 4;
   localparam int HIST_SEL_BITS = 2;
   localparam int STEP_BITS     = 4;

   localparam logic [REG_IDX_BITS-1:0] REG_FB_ZERO = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FF_ZERO = 3'd4;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = 24'sd1048576;

   typedef enum logic [1:0] {
      OPND_X,
      OPND_W,
      OPND_HIST
   } opnd_type;

   typedef enum logic {
      ACC_FB,
      ACC_FF
   } acc_tgt_type;

   typedef struct packed {
      logic                      load_x;
      logic                      mul_en;
      logic [REG_IDX_BITS-1:0]   coef_idx;
      opnd_type                  opnd;
      logic [HIST_SEL_BITS-1:0]  hist_idx;
      acc_tgt_type               tgt;
      logic                      acc_first;
      logic                      acc_sub;
      logic                      fin_w;
      logic                      fin_y;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ctl_stat_type;

endpackage

`default_nettype wire

>>> rtl/iirdf2_ctrl.sv
// ----------------------------------------------------------------------------
// iirdf2_ctrl
// step sequencer issuing multiply, accumulate and rounding commands per item
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2_ctrl
   import iirdf2_pkg::*;
#(
   parameter int ORDER = ORDER_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       cmd
);

   localparam int STEP_FIN_W = ORDER + 2;
   localparam int STEP_B0    = (ORDER + 3 > 2 * ORDER + 1) ? ORDER + 3 : 2 * ORDER + 1;
   localparam int STEP_FIN_Y = STEP_B0 + 2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.opnd   = OPND_X;
      cmd.tgt    = ACC_FB;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_RUN;
               step_in    = '0;
            end
         end
         ST_RUN: begin
            priority if (step_ff == '0) begin
               cmd.mul_en    = 1'b1;
               cmd.coef_idx  = REG_FB_ZERO;
               cmd.opnd      = OPND_X;
               cmd.tgt       = ACC_FB;
               cmd.acc_first = 1'b1;
            end else if (step_ff <= STEP_BITS'(ORDER)) begin
               cmd.mul_en   = 1'b1;
               cmd.coef_idx = REG_FB_ZERO + REG_IDX_BITS'(step_ff);
               cmd.opnd     = OPND_HIST;
               cmd.hist_idx = HIST_SEL_BITS'(step_ff - STEP_BITS'(1));
               cmd.tgt      = ACC_FB;
               cmd.acc_sub  = 1'b1;
            end else if (step_ff <= STEP_BITS'(2 * ORDER)) begin
               cmd.mul_en    = 1'b1;
               cmd.coef_idx  = REG_FF_ZERO + REG_IDX_BITS'(step_ff - STEP_BITS'(ORDER));
               cmd.opnd      = OPND_HIST;
               cmd.hist_idx  = HIST_SEL_BITS'(step_ff - STEP_BITS'(ORDER + 1));
               cmd.tgt       = ACC_FF;
               cmd.acc_first = (step_ff == STEP_BITS'(ORDER + 1));
            end else if (step_ff == STEP_BITS'(STEP_B0)) begin
               cmd.mul_en   = 1'b1;
               cmd.coef_idx = REG_FF_ZERO;
               cmd.opnd     = OPND_W;
               cmd.tgt      = ACC_FF;
            end else begin
               cmd.mul_en = 1'b0;
            end

            cmd.fin_w = (step_ff == STEP_BITS'(STEP_FIN_W));

            if (step_ff == STEP_BITS'(STEP_FIN_Y)) begin
               if (!stat.out_busy) begin
                  cmd.fin_y = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/iirdf2_dpath.sv
// ----------------------------------------------------------------------------
// iirdf2_dpath
// coefficient store, history, shared multiplier, accumulators and rounding
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2_dpath
   import iirdf2_pkg::*;
#(
   parameter int ORDER       = ORDER_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_cmd_type             cmd,
   output ctl_stat_type                 stat,
   input  wire logic [SAMPLE_BITS-1:0]  req_sample,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]    csr_wdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [SAMPLE_BITS-1:0]       rsp_sample,
   output logic                         rsp_clipped
);

   localparam int HIST_IDX_BITS = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int W_WIDE_BITS   = ACC_BITS - COEF_FRAC;
   localparam int Y_SHIFT       = COEF_FRAC + HIST_FRAC;
   localparam int Y_WIDE_BITS   = ACC_BITS - Y_SHIFT;

   localparam logic signed [ACC_BITS-1:0] RND_W = ACC_BITS'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [ACC_BITS-1:0] RND_Y = ACC_BITS'(1) <<< (Y_SHIFT - 1);
   localparam logic signed [HIST_BITS-1:0] HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
   localparam logic signed [HIST_BITS-1:0] HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic        vld;
      acc_tgt_type tgt;
      logic        first;
      logic        sub;
   } prod_tag_type;

   logic signed [COEF_BITS-1:0]   coef_ff [NUM_REGS];
   logic signed [COEF_BITS-1:0]   coef_in [NUM_REGS];
   logic signed [HIST_BITS-1:0]   hist_ff [ORDER];
   logic signed [HIST_BITS-1:0]   hist_in [ORDER];
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [HIST_BITS-1:0]   w_ff, w_in;
   logic                          sat_w_ff, sat_w_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   prod_tag_type                  tag_ff, tag_in;
   logic signed [ACC_BITS-1:0]    acc_fb_ff, acc_fb_in;
   logic signed [ACC_BITS-1:0]    acc_ff_ff, acc_ff_in;
   logic                          out_vld_ff, out_vld_in;
   logic [SAMPLE_BITS-1:0]        out_smp_ff, out_smp_in;
   logic                          out_clip_ff, out_clip_in;

   logic signed [COEF_BITS-1:0]   coef_rd;
   logic signed [HIST_BITS-1:0]   opnd;
   logic signed [ACC_BITS-1:0]    acc_base, acc_sum, prod_ext;
   logic signed [ACC_BITS-1:0]    fb_rnd, ff_rnd;
   logic [W_WIDE_BITS-1:0]        w_wide;
   logic [Y_WIDE_BITS-1:0]        y_wide;
   logic                          w_ovf, y_ovf;

   // operand select and multiply
   always_comb begin
      coef_rd = coef_ff[cmd.coef_idx];
      unique case (cmd.opnd)
         OPND_X:    opnd = HIST_BITS'(x_ff) <<< HIST_FRAC;
         OPND_W:    opnd = w_ff;
         OPND_HIST: opnd = hist_ff[cmd.hist_idx[HIST_IDX_BITS-1:0]];
         default:   opnd = '0;
      endcase
      prod_in    = coef_rd * opnd;
      tag_in.vld   = cmd.mul_en;
      tag_in.tgt   = cmd.tgt;
      tag_in.first = cmd.acc_first;
      tag_in.sub   = cmd.acc_sub;
   end

   // accumulate
   always_comb begin
      prod_ext = ACC_BITS'(prod_ff);
      if (tag_ff.first) begin
         acc_base = '0;
      end else if (tag_ff.tgt == ACC_FB) begin
         acc_base = acc_fb_ff;
      end else begin
         acc_base = acc_ff_ff;
      end
      acc_sum   = tag_ff.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
      acc_fb_in = acc_fb_ff;
      acc_ff_in = acc_ff_ff;
      if (tag_ff.vld) begin
         if (tag_ff.tgt == ACC_FB) begin
            acc_fb_in = acc_sum;
         end else begin
            acc_ff_in = acc_sum;
         end
      end
   end

   // round and saturate the feedback node
   always_comb begin
      fb_rnd   = acc_fb_ff + RND_W;
      w_wide   = fb_rnd[ACC_BITS-1:COEF_FRAC];
      w_ovf    = (w_wide[W_WIDE_BITS-1:HIST_BITS-1]
                  != {(W_WIDE_BITS-HIST_BITS+1){w_wide[W_WIDE_BITS-1]}});
      w_in     = w_ff;
      sat_w_in = sat_w_ff;
      if (cmd.fin_w) begin
         sat_w_in = w_ovf;
         if (w_ovf) begin
            w_in = w_wide[W_WIDE_BITS-1] ? HIST_MIN : HIST_MAX;
         end else begin
            w_in = w_wide[HIST_BITS-1:0];
         end
      end
   end

   // round and saturate the output, shift history
   always_comb begin
      ff_rnd      = acc_ff_ff + RND_Y;
      y_wide      = ff_rnd[ACC_BITS-1:Y_SHIFT];
      y_ovf       = (y_wide[Y_WIDE_BITS-1:SAMPLE_BITS-1]
                     != {(Y_WIDE_BITS-SAMPLE_BITS+1){y_wide[Y_WIDE_BITS-1]}});
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_smp_in  = out_smp_ff;
      out_clip_in = out_clip_ff;
      hist_in     = hist_ff;
      if (cmd.fin_y) begin
         out_vld_in  = 1'b1;
         out_clip_in = sat_w_ff || y_ovf;
         if (y_ovf) begin
            out_smp_in = y_wide[Y_WIDE_BITS-1] ? SMP_MIN : SMP_MAX;
         end else begin
            out_smp_in = y_wide[SAMPLE_BITS-1:0];
         end
         for (int i = ORDER - 1; i > 0; i--) begin
            hist_in[i] = hist_ff[i-1];
         end
         hist_in[0] = w_ff;
      end
   end

   // coefficient writes and sample capture
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en && (csr_index < CSR_IDX_BITS'(NUM_REGS))) begin
         coef_in[csr_index[REG_IDX_BITS-1:0]] = csr_wdata;
      end
      x_in = cmd.load_x ? req_sample : x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= ((REG_IDX_BITS'(i) == REG_FB_ZERO) || (REG_IDX_BITS'(i) == REG_FF_ZERO))
                          ? COEF_ONE : '0;
         end
         for (int i = 0; i < ORDER; i++) begin
            hist_ff[i] <= '0;
         end
         tag_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         coef_ff    <= coef_in;
         hist_ff    <= hist_in;
         tag_ff     <= tag_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      w_ff        <= w_in;
      sat_w_ff    <= sat_w_in;
      prod_ff     <= prod_in;
      acc_fb_ff   <= acc_fb_in;
      acc_ff_ff   <= acc_ff_in;
      out_smp_ff  <= out_smp_in;
      out_clip_ff <= out_clip_in;
   end

   assign stat.out_busy = out_vld_ff && !rsp_tready;
   assign rsp_tvalid    = out_vld_ff;
   assign rsp_sample    = out_smp_ff;
   assign rsp_clipped   = out_clip_ff;

endmodule

`default_nettype wire

>>> rtl/iir_direct_form_two_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter
// third-order direct form II iir filter with one shared multiply-accumulate
//
//   channel  dir  handshake          contents
//   req_     in   tvalid / tready    tdata: sample_in
//   rsp_     out  tvalid / tready    tdata: sample_out, tuser: clipped
//   csr_     in   wr_en              index 0..7, wdata coefficient q4.20
//
// one item at a time, paced by the single 24x32 multiplier
// and by the wait for the rounded node w
// before b0 * w can be formed
// reset restores a0 = b0 = 1.0, other coefficients and history to zero
// a held result stalls the last step; history shifts only when it is stored
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_two_filter
   import iirdf2_pkg::*;
#(
   parameter int ORDER       = ORDER_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [DATA_W-1:0]       req_tdata,   // sample_in
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [DATA_W-1:0]            rsp_tdata,   // sample_out
   output logic                         rsp_tuser,   // clipped
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]    csr_wdata
);

   ctl_cmd_type            cmd;
   ctl_stat_type           stat;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   iirdf2_ctrl #(
      .ORDER (ORDER)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   iirdf2_dpath #(
      .ORDER       (ORDER),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (rsp_sample),
      .rsp_clipped (rsp_tuser)
   );

   assign rsp_tdata = DATA_W'(rsp_sample);

endmodule

`default_nettype wire

>>> rtl/iirdf2_checker.sv
// ----------------------------------------------------------------------------
// iirdf2_checker
// port-level checks on the filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "iir_direct_form_two_filter_macros.svh"

module iirdf2_checker
   import iirdf2_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tvalid,
   input wire logic                    req_tready,
   input wire logic [DATA_W-1:0]       req_tdata,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [DATA_W-1:0]       rsp_tdata,
   input wire logic                    rsp_tuser,
   input wire logic                    csr_wr_en,
   input wire logic [CSR_IDX_BITS-1:0] csr_index,
   input wire logic [COEF_BITS-1:0]    csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_wr_en, csr_index, csr_wdata};

   `IIRDF2_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `IIRDF2_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "item taken while one is in flight")
   `IIRDF2_ASSERT_SAME(a_done_has_result, $rose(req_tready), rsp_tvalid, "item finished without a result")

endmodule

bind iir_direct_form_two_filter iirdf2_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_wr_en  (csr_wr_en),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire
